### rtl/w15sf_pkg.sv
`timescale 1ns / 1ps

package w15sf_pkg;

   // fixed-point format of all values
   localparam int FRAC_BITS  = 16;
   localparam int VAL_W      = 26;
   localparam int OUT_W      = 21;
   localparam int NODE_W     = 4;
   localparam int NODE_COUNT = 15;
   localparam int R_W        = 17;
   localparam int S_W        = 17;
   localparam int T_W        = 18;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [OUT_W-1:0] out_type;
   typedef logic [NODE_W-1:0]       node_type;

   localparam val_type ONE      = val_type'(longint'(1) << FRAC_BITS);
   localparam val_type HALF     = val_type'(longint'(1) << (FRAC_BITS - 1));
   localparam val_type OUT_MAX  = val_type'((longint'(1) << (OUT_W - 1)) - 1);
   localparam val_type OUT_MIN  = val_type'(-(longint'(1) << (OUT_W - 1)));
   localparam node_type LAST_NODE = node_type'(NODE_COUNT - 1);
   localparam logic signed [2*VAL_W-1:0] MUL_RND =
      (2*VAL_W)'(longint'(1) << (FRAC_BITS - 1));

   // node families of the wedge
   typedef enum logic [1:0] {
      CLS_CORNER,
      CLS_MIDSIDE,
      CLS_VERT
   } cls_type;

   // per-node context carried down the pipeline
   typedef struct packed {
      node_type   node;
      cls_type    cls;
      logic       top;
      logic [1:0] sub;
      val_type    r;
      val_type    s;
      val_type    t;
      val_type    u;
      val_type    f;
      val_type    x;
   } ctx_type;

   // product rounded to nearest, ties toward plus infinity
   function automatic val_type mulr(input val_type a, input val_type b);
      logic signed [2*VAL_W-1:0] p;
      p = (2*VAL_W)'(a) * (2*VAL_W)'(b) + MUL_RND;
      return val_type'(p >>> FRAC_BITS);
   endfunction

   // halve with rounding up on ties
   function automatic val_type half(input val_type a);
      return (a + val_type'(1)) >>> 1;
   endfunction

   // clamp to the output range
   function automatic out_type sat(input val_type v);
      val_type c;
      c = v;
      if (c > OUT_MAX) c = OUT_MAX;
      if (c < OUT_MIN) c = OUT_MIN;
      return out_type'(c);
   endfunction

endpackage

### rtl/wedge15_shape_function_eval.sv
`timescale 1ns / 1ps

// channel   direction  ports                               handshake
// request   in         req_coord_r/s/t                     start & !busy
// response  out        rsp_node_index .. rsp_last_node     rsp_valid, one cycle
//
// one point gives 15 words, one per cycle; a new point is taken once the node counter,
// which feeds one node a cycle into the pipeline, reaches the last node of the current point.
// after the accept, the first word passes the node counter (issue), two multiply stages and the combine stage.
// reset clears the node counter and the stage valid bits; no storage needs clearing.
// the receiver cannot stall: busy only covers the node sweep of the current point.

module wedge15_shape_function_eval (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [w15sf_pkg::R_W-1:0]            req_coord_r,
   input  logic [w15sf_pkg::S_W-1:0]            req_coord_s,
   input  logic signed [w15sf_pkg::T_W-1:0]     req_coord_t,
   output logic                                 rsp_valid,
   output logic [w15sf_pkg::NODE_W-1:0]         rsp_node_index,
   output logic signed [w15sf_pkg::OUT_W-1:0]   rsp_shape_value,
   output logic signed [w15sf_pkg::OUT_W-1:0]   rsp_grad_r,
   output logic signed [w15sf_pkg::OUT_W-1:0]   rsp_grad_s,
   output logic signed [w15sf_pkg::OUT_W-1:0]   rsp_grad_t,
   output logic signed [w15sf_pkg::OUT_W-1:0]   rsp_curv_rr,
   output logic signed [w15sf_pkg::OUT_W-1:0]   rsp_curv_ss,
   output logic signed [w15sf_pkg::OUT_W-1:0]   rsp_curv_tt,
   output logic signed [w15sf_pkg::OUT_W-1:0]   rsp_curv_rs,
   output logic signed [w15sf_pkg::OUT_W-1:0]   rsp_curv_st,
   output logic signed [w15sf_pkg::OUT_W-1:0]   rsp_curv_rt,
   output logic                                 rsp_last_node
);

   logic                               accept;
   logic                               act_ff, act_in;
   w15sf_pkg::node_type                node_ff, node_in;
   logic [w15sf_pkg::R_W-1:0]          crd_r_ff;
   logic [w15sf_pkg::S_W-1:0]          crd_s_ff;
   logic signed [w15sf_pkg::T_W-1:0]   crd_t_ff;

   w15sf_pkg::ctx_type   s1_ctx_ff, s1_ctx_in;
   w15sf_pkg::val_type   s1_a1_ff, s1_a1_in, s1_a2_ff, s1_a2_in;
   w15sf_pkg::val_type   s1_b1_ff, s1_b1_in, s1_b2_ff, s1_b2_in;
   w15sf_pkg::val_type   s1_c1_ff, s1_c1_in, s1_c2_ff, s1_c2_in;
   logic                 s1_vld_ff;

   w15sf_pkg::ctx_type   s2_ctx_ff;
   w15sf_pkg::val_type   s2_ma_ff, s2_ma_in, s2_mb_ff, s2_mb_in;
   w15sf_pkg::val_type   s2_mc_ff, s2_mc_in, s2_mtt_ff, s2_mtt_in;
   logic                 s2_vld_ff;

   w15sf_pkg::ctx_type   s3_ctx_ff;
   w15sf_pkg::val_type   s3_ma_ff, s3_mb_ff, s3_mc_ff;
   w15sf_pkg::val_type   s3_q_ff, s3_q_in, s3_md_ff, s3_md_in, s3_me_ff, s3_me_in;
   logic                 s3_vld_ff;

   w15sf_pkg::out_type   o_n_ff, o_gr_ff, o_gs_ff, o_gt_ff, o_rr_ff;
   w15sf_pkg::out_type   o_ss_ff, o_tt_ff, o_rs_ff, o_st_ff, o_rt_ff;
   w15sf_pkg::out_type   o_n_in, o_gr_in, o_gs_in, o_gt_in, o_rr_in;
   w15sf_pkg::out_type   o_ss_in, o_tt_in, o_rs_in, o_st_in, o_rt_in;
   w15sf_pkg::node_type  o_node_ff;
   logic                 o_last_ff, o_vld_ff;

   // node sweep control
   assign busy   = act_ff && (node_ff != w15sf_pkg::LAST_NODE);
   assign accept = start && !busy;

   always_comb begin
      act_in  = act_ff;
      node_in = node_ff;
      if (act_ff) begin
         node_in = node_ff + w15sf_pkg::node_type'(1);
         if (node_ff == w15sf_pkg::LAST_NODE) begin
            act_in = 1'b0;
         end
      end
      if (accept) begin
         act_in  = 1'b1;
         node_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         node_ff <= '0;
      end else begin
         act_ff  <= act_in;
         node_ff <= node_in;
      end
   end

   // point capture
   always_ff @(posedge clock) begin
      if (accept) begin
         crd_r_ff <= req_coord_r;
         crd_s_ff <= req_coord_s;
         crd_t_ff <= req_coord_t;
      end
   end

   // stage 1: node decode and multiplier operands
   always_comb begin
      w15sf_pkg::val_type r, s, t, u, tm, tp, f, x, lin1;
      r    = w15sf_pkg::val_type'({1'b0, crd_r_ff});
      s    = w15sf_pkg::val_type'({1'b0, crd_s_ff});
      t    = w15sf_pkg::val_type'(crd_t_ff);
      u    = w15sf_pkg::ONE - r - s;
      tm   = w15sf_pkg::ONE - t;
      tp   = w15sf_pkg::ONE + t;

      s1_ctx_in      = '0;
      s1_ctx_in.node = node_ff;
      unique case (node_ff)
         4'd0:  begin s1_ctx_in.cls = w15sf_pkg::CLS_CORNER;  s1_ctx_in.top = 1'b0;
                      s1_ctx_in.sub = 2'd0; end
         4'd1:  begin s1_ctx_in.cls = w15sf_pkg::CLS_CORNER;  s1_ctx_in.top = 1'b0;
                      s1_ctx_in.sub = 2'd1; end
         4'd2:  begin s1_ctx_in.cls = w15sf_pkg::CLS_CORNER;  s1_ctx_in.top = 1'b0;
                      s1_ctx_in.sub = 2'd2; end
         4'd3:  begin s1_ctx_in.cls = w15sf_pkg::CLS_CORNER;  s1_ctx_in.top = 1'b1;
                      s1_ctx_in.sub = 2'd0; end
         4'd4:  begin s1_ctx_in.cls = w15sf_pkg::CLS_CORNER;  s1_ctx_in.top = 1'b1;
                      s1_ctx_in.sub = 2'd1; end
         4'd5:  begin s1_ctx_in.cls = w15sf_pkg::CLS_CORNER;  s1_ctx_in.top = 1'b1;
                      s1_ctx_in.sub = 2'd2; end
         4'd6:  begin s1_ctx_in.cls = w15sf_pkg::CLS_MIDSIDE; s1_ctx_in.top = 1'b0;
                      s1_ctx_in.sub = 2'd0; end
         4'd7:  begin s1_ctx_in.cls = w15sf_pkg::CLS_MIDSIDE; s1_ctx_in.top = 1'b0;
                      s1_ctx_in.sub = 2'd1; end
         4'd8:  begin s1_ctx_in.cls = w15sf_pkg::CLS_MIDSIDE; s1_ctx_in.top = 1'b0;
                      s1_ctx_in.sub = 2'd2; end
         4'd9:  begin s1_ctx_in.cls = w15sf_pkg::CLS_MIDSIDE; s1_ctx_in.top = 1'b1;
                      s1_ctx_in.sub = 2'd0; end
         4'd10: begin s1_ctx_in.cls = w15sf_pkg::CLS_MIDSIDE; s1_ctx_in.top = 1'b1;
                      s1_ctx_in.sub = 2'd1; end
         4'd11: begin s1_ctx_in.cls = w15sf_pkg::CLS_MIDSIDE; s1_ctx_in.top = 1'b1;
                      s1_ctx_in.sub = 2'd2; end
         4'd12: begin s1_ctx_in.cls = w15sf_pkg::CLS_VERT;    s1_ctx_in.top = 1'b0;
                      s1_ctx_in.sub = 2'd0; end
         4'd13: begin s1_ctx_in.cls = w15sf_pkg::CLS_VERT;    s1_ctx_in.top = 1'b0;
                      s1_ctx_in.sub = 2'd1; end
         4'd14: begin s1_ctx_in.cls = w15sf_pkg::CLS_VERT;    s1_ctx_in.top = 1'b0;
                      s1_ctx_in.sub = 2'd2; end
         default: begin s1_ctx_in.cls = w15sf_pkg::CLS_CORNER; s1_ctx_in.top = 1'b0;
                      s1_ctx_in.sub = 2'd0; end
      endcase

      f = s1_ctx_in.top ? tp : tm;
      unique case (s1_ctx_in.sub)
         2'd0:    x = u;
         2'd1:    x = r;
         default: x = s;
      endcase
      lin1 = (x <<< 1) - w15sf_pkg::ONE;

      s1_ctx_in.r = r;
      s1_ctx_in.s = s;
      s1_ctx_in.t = t;
      s1_ctx_in.u = u;
      s1_ctx_in.f = f;
      s1_ctx_in.x = x;

      s1_a1_in = '0; s1_a2_in = '0;
      s1_b1_in = '0; s1_b2_in = '0;
      s1_c1_in = '0; s1_c2_in = '0;
      unique case (s1_ctx_in.cls)
         w15sf_pkg::CLS_CORNER: begin
            s1_a1_in = x;
            s1_a2_in = lin1;
            s1_b1_in = f;
            s1_b2_in = (x <<< 2) - w15sf_pkg::ONE;
            s1_c1_in = x;
            s1_c2_in = s1_ctx_in.top ? (t <<< 1) + lin1 : (t <<< 1) - lin1;
         end
         w15sf_pkg::CLS_MIDSIDE: begin
            s1_b1_in = f;
            s1_c1_in = f;
            unique case (s1_ctx_in.sub)
               2'd0: begin
                  s1_a1_in = r; s1_a2_in = u; s1_b2_in = u - r; s1_c2_in = r;
               end
               2'd1: begin
                  s1_a1_in = r; s1_a2_in = s; s1_b2_in = s;     s1_c2_in = r;
               end
               default: begin
                  s1_a1_in = s; s1_a2_in = u; s1_b2_in = s;     s1_c2_in = u - s;
               end
            endcase
         end
         w15sf_pkg::CLS_VERT: begin
            s1_a1_in = t;
            s1_a2_in = x;
         end
         default: begin
            s1_a1_in = '0;
         end
      endcase
   end

   // stage 2: first products
   always_comb begin
      s2_ma_in  = w15sf_pkg::mulr(s1_a1_ff, s1_a2_ff);
      s2_mb_in  = w15sf_pkg::mulr(s1_b1_ff, s1_b2_ff);
      s2_mc_in  = w15sf_pkg::mulr(s1_c1_ff, s1_c2_ff);
      s2_mtt_in = w15sf_pkg::mulr(s1_ctx_ff.t, s1_ctx_ff.t);
   end

   // stage 3: second products on the first ones
   always_comb begin
      s3_q_in  = w15sf_pkg::ONE - s2_mtt_ff;
      s3_md_in = w15sf_pkg::mulr(s2_ctx_ff.f, s2_ma_ff);
      s3_me_in = w15sf_pkg::mulr(s3_q_in, s2_ctx_ff.x);
   end

   // stage 4: per-family combine and saturation
   always_comb begin
      w15sf_pkg::ctx_type c;
      w15sf_pkg::val_type n, gr, gs, gt, rr, ss, tt, rs, st, rt;
      w15sf_pkg::val_type f2, f4, dpos, dneg, w, base, lin;
      c    = s3_ctx_ff;
      f2   = c.f <<< 1;
      f4   = c.f <<< 2;
      dpos = w15sf_pkg::half(s3_mb_ff - s3_q_ff);
      dneg = w15sf_pkg::half(s3_q_ff - s3_mb_ff);
      w    = (c.x <<< 1) - w15sf_pkg::HALF;
      base = c.top ? w + c.t : w - c.t;
      lin  = ((c.sub == 2'd0) != c.top) ? base : -base;
      n  = '0; gr = '0; gs = '0; gt = '0; rr = '0;
      ss = '0; tt = '0; rs = '0; st = '0; rt = '0;
      unique case (c.cls)
         w15sf_pkg::CLS_CORNER: begin
            n  = w15sf_pkg::half(s3_md_ff - s3_me_ff);
            gt = w15sf_pkg::half(s3_mc_ff);
            tt = c.x;
            unique case (c.sub)
               2'd0: begin
                  gr = dneg; gs = dneg; rr = f2; ss = f2; rs = f2; st = lin; rt = lin;
               end
               2'd1: begin
                  gr = dpos; rr = f2; rt = lin;
               end
               default: begin
                  gs = dpos; ss = f2; st = lin;
               end
            endcase
         end
         w15sf_pkg::CLS_MIDSIDE: begin
            n  = s3_md_ff <<< 1;
            gt = c.top ? (s3_ma_ff <<< 1) : -(s3_ma_ff <<< 1);
            unique case (c.sub)
               2'd0: begin
                  gr = s3_mb_ff <<< 1; gs = -(s3_mc_ff <<< 1);
                  rr = -f4; rs = -f2; st = c.r <<< 1; rt = (c.r - c.u) <<< 1;
               end
               2'd1: begin
                  gr = s3_mb_ff <<< 1; gs = s3_mc_ff <<< 1;
                  rs = f2; st = -(c.r <<< 1); rt = -(c.s <<< 1);
               end
               default: begin
                  gr = -(s3_mb_ff <<< 1); gs = s3_mc_ff <<< 1;
                  ss = -f4; rs = -f2; st = (c.s - c.u) <<< 1; rt = c.s <<< 1;
               end
            endcase
            // top edge flips the mixed t terms
            if (c.top) begin
               st = -st;
               rt = -rt;
            end
         end
         w15sf_pkg::CLS_VERT: begin
            n  = s3_me_ff;
            gt = -(s3_ma_ff <<< 1);
            tt = -(c.x <<< 1);
            unique case (c.sub)
               2'd0: begin
                  gr = -s3_q_ff; gs = -s3_q_ff; st = c.t <<< 1; rt = c.t <<< 1;
               end
               2'd1: begin
                  gr = s3_q_ff; rt = -(c.t <<< 1);
               end
               default: begin
                  gs = s3_q_ff; st = -(c.t <<< 1);
               end
            endcase
         end
         default: begin
            n = '0;
         end
      endcase
      o_n_in  = w15sf_pkg::sat(n);
      o_gr_in = w15sf_pkg::sat(gr);
      o_gs_in = w15sf_pkg::sat(gs);
      o_gt_in = w15sf_pkg::sat(gt);
      o_rr_in = w15sf_pkg::sat(rr);
      o_ss_in = w15sf_pkg::sat(ss);
      o_tt_in = w15sf_pkg::sat(tt);
      o_rs_in = w15sf_pkg::sat(rs);
      o_st_in = w15sf_pkg::sat(st);
      o_rt_in = w15sf_pkg::sat(rt);
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         s1_vld_ff <= act_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         o_vld_ff  <= s3_vld_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      s1_ctx_ff <= s1_ctx_in;
      s1_a1_ff  <= s1_a1_in;
      s1_a2_ff  <= s1_a2_in;
      s1_b1_ff  <= s1_b1_in;
      s1_b2_ff  <= s1_b2_in;
      s1_c1_ff  <= s1_c1_in;
      s1_c2_ff  <= s1_c2_in;

      s2_ctx_ff <= s1_ctx_ff;
      s2_ma_ff  <= s2_ma_in;
      s2_mb_ff  <= s2_mb_in;
      s2_mc_ff  <= s2_mc_in;
      s2_mtt_ff <= s2_mtt_in;

      s3_ctx_ff <= s2_ctx_ff;
      s3_ma_ff  <= s2_ma_ff;
      s3_mb_ff  <= s2_mb_ff;
      s3_mc_ff  <= s2_mc_ff;
      s3_q_ff   <= s3_q_in;
      s3_md_ff  <= s3_md_in;
      s3_me_ff  <= s3_me_in;

      o_node_ff <= s3_ctx_ff.node;
      o_last_ff <= (s3_ctx_ff.node == w15sf_pkg::LAST_NODE);
      o_n_ff    <= o_n_in;
      o_gr_ff   <= o_gr_in;
      o_gs_ff   <= o_gs_in;
      o_gt_ff   <= o_gt_in;
      o_rr_ff   <= o_rr_in;
      o_ss_ff   <= o_ss_in;
      o_tt_ff   <= o_tt_in;
      o_rs_ff   <= o_rs_in;
      o_st_ff   <= o_st_in;
      o_rt_ff   <= o_rt_in;
   end

   // result word
   assign rsp_valid       = o_vld_ff;
   assign rsp_node_index  = o_node_ff;
   assign rsp_shape_value = o_n_ff;
   assign rsp_grad_r      = o_gr_ff;
   assign rsp_grad_s      = o_gs_ff;
   assign rsp_grad_t      = o_gt_ff;
   assign rsp_curv_rr     = o_rr_ff;
   assign rsp_curv_ss     = o_ss_ff;
   assign rsp_curv_tt     = o_tt_ff;
   assign rsp_curv_rs     = o_rs_ff;
   assign rsp_curv_st     = o_st_ff;
   assign rsp_curv_rt     = o_rt_ff;
   assign rsp_last_node   = o_last_ff;

   // an accepted point starts its sweep at node zero
   a_start_sweep: assert property (@(posedge clock) disable iff (reset)
      accept |=> (act_ff && node_ff == '0))
      else $error("sweep did not start at node zero");

   // the last flag marks node fourteen only
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_node == (rsp_node_index == w15sf_pkg::LAST_NODE)))
      else $error("last flag and node index disagree");

   // words of one point come back to back in node order
   a_node_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_node) |=>
         (rsp_valid && rsp_node_index == $past(rsp_node_index) + 4'd1))
      else $error("node words out of order");

endmodule

### bench/wedge15_shape_function_eval_tb.sv
`timescale 1ns / 1ps

module wedge15_shape_function_eval_tb;

   typedef struct {
      logic [w15sf_pkg::NODE_W-1:0] node;
      longint                       vals [10];
      logic                         last;
   } node_word_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [w15sf_pkg::R_W-1:0] req_coord_r;
   logic [w15sf_pkg::S_W-1:0] req_coord_s;
   logic signed [w15sf_pkg::T_W-1:0] req_coord_t;
   logic rsp_valid;
   logic [w15sf_pkg::NODE_W-1:0] rsp_node_index;
   logic signed [w15sf_pkg::OUT_W-1:0] rsp_shape_value, rsp_grad_r, rsp_grad_s, rsp_grad_t;
   logic signed [w15sf_pkg::OUT_W-1:0] rsp_curv_rr, rsp_curv_ss, rsp_curv_tt;
   logic signed [w15sf_pkg::OUT_W-1:0] rsp_curv_rs, rsp_curv_st, rsp_curv_rt;
   logic rsp_last_node;

   node_word_type pending_words [$];
   int mismatch_count;
   int idle_pct;

   wedge15_shape_function_eval DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coord_r(req_coord_r), .req_coord_s(req_coord_s), .req_coord_t(req_coord_t),
      .rsp_valid(rsp_valid), .rsp_node_index(rsp_node_index),
      .rsp_shape_value(rsp_shape_value), .rsp_grad_r(rsp_grad_r),
      .rsp_grad_s(rsp_grad_s), .rsp_grad_t(rsp_grad_t),
      .rsp_curv_rr(rsp_curv_rr), .rsp_curv_ss(rsp_curv_ss), .rsp_curv_tt(rsp_curv_tt),
      .rsp_curv_rs(rsp_curv_rs), .rsp_curv_st(rsp_curv_st), .rsp_curv_rt(rsp_curv_rt),
      .rsp_last_node(rsp_last_node)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // rounded product, ties toward plus infinity
   function automatic longint fx_mul(longint a, longint b);
      return (a * b + (longint'(1) << (w15sf_pkg::FRAC_BITS - 1))) >>> w15sf_pkg::FRAC_BITS;
   endfunction

   function automatic longint fx_half(longint a);
      return (a + 1) >>> 1;
   endfunction

   function automatic longint clamp_out(longint v);
      if (v > 1048575) return 1048575;
      if (v < -1048576) return -1048576;
      return v;
   endfunction

   // expected node words for one point
   task automatic predict_wedge_nodes(logic [w15sf_pkg::R_W-1:0] rr,
                                      logic [w15sf_pkg::S_W-1:0] ss,
                                      logic signed [w15sf_pkg::T_W-1:0] tt);
      longint v [15][10];
      longint r, s, t, one, hf, u, tm, tp, q;
      node_word_type w;
      r = longint'(rr); s = longint'(ss); t = longint'(tt);
      one = longint'(1) << w15sf_pkg::FRAC_BITS;
      hf = one / 2;
      u = one - r - s; tm = one - t; tp = one + t;
      q = one - fx_mul(t, t);
      foreach (v[k, j]) v[k][j] = 0;
      // bottom corners
      v[0][0] = fx_half(fx_mul(tm, fx_mul(u, 2*u - one)) - fx_mul(q, u));
      v[0][1] = fx_half(q - fx_mul(tm, 4*u - one)); v[0][2] = v[0][1];
      v[0][3] = fx_half(fx_mul(u, 2*t - 2*u + one));
      v[0][4] = 2*tm; v[0][5] = 2*tm; v[0][6] = u; v[0][7] = 2*tm;
      v[0][8] = 2*u - hf - t; v[0][9] = v[0][8];
      v[1][0] = fx_half(fx_mul(tm, fx_mul(r, 2*r - one)) - fx_mul(q, r));
      v[1][1] = fx_half(fx_mul(tm, 4*r - one) - q);
      v[1][3] = fx_half(fx_mul(r, one - 2*r + 2*t));
      v[1][4] = 2*tm; v[1][6] = r; v[1][9] = hf - 2*r + t;
      v[2][0] = fx_half(fx_mul(tm, fx_mul(s, 2*s - one)) - fx_mul(q, s));
      v[2][2] = fx_half(fx_mul(tm, 4*s - one) - q);
      v[2][3] = fx_half(fx_mul(s, one - 2*s + 2*t));
      v[2][5] = 2*tm; v[2][6] = s; v[2][8] = hf - 2*s + t;
      // top corners
      v[3][0] = fx_half(fx_mul(tp, fx_mul(u, 2*u - one)) - fx_mul(q, u));
      v[3][1] = fx_half(q - fx_mul(tp, 4*u - one)); v[3][2] = v[3][1];
      v[3][3] = fx_half(fx_mul(u, 2*t + 2*u - one));
      v[3][4] = 2*tp; v[3][5] = 2*tp; v[3][6] = u; v[3][7] = 2*tp;
      v[3][8] = hf - 2*u - t; v[3][9] = v[3][8];
      v[4][0] = fx_half(fx_mul(tp, fx_mul(r, 2*r - one)) - fx_mul(q, r));
      v[4][1] = fx_half(fx_mul(tp, 4*r - one) - q);
      v[4][3] = fx_half(fx_mul(r, 2*r - one + 2*t));
      v[4][4] = 2*tp; v[4][6] = r; v[4][9] = 2*r - hf + t;
      v[5][0] = fx_half(fx_mul(tp, fx_mul(s, 2*s - one)) - fx_mul(q, s));
      v[5][2] = fx_half(fx_mul(tp, 4*s - one) - q);
      v[5][3] = fx_half(fx_mul(s, 2*s - one + 2*t));
      v[5][5] = 2*tp; v[5][6] = s; v[5][8] = 2*s - hf + t;
      // bottom edge midpoints
      v[6][0] = 2*fx_mul(tm, fx_mul(r, u));
      v[6][1] = 2*fx_mul(tm, u - r); v[6][2] = -2*fx_mul(tm, r); v[6][3] = -2*fx_mul(r, u);
      v[6][4] = -4*tm; v[6][7] = -2*tm; v[6][8] = 2*r; v[6][9] = 2*(r - u);
      v[7][0] = 2*fx_mul(tm, fx_mul(r, s));
      v[7][1] = 2*fx_mul(tm, s); v[7][2] = 2*fx_mul(tm, r); v[7][3] = -2*fx_mul(r, s);
      v[7][7] = 2*tm; v[7][8] = -2*r; v[7][9] = -2*s;
      v[8][0] = 2*fx_mul(tm, fx_mul(s, u));
      v[8][1] = -2*fx_mul(tm, s); v[8][2] = 2*fx_mul(tm, u - s); v[8][3] = -2*fx_mul(s, u);
      v[8][5] = -4*tm; v[8][7] = -2*tm; v[8][8] = 2*(s - u); v[8][9] = 2*s;
      // top edge midpoints
      v[9][0] = 2*fx_mul(tp, fx_mul(r, u));
      v[9][1] = 2*fx_mul(tp, u - r); v[9][2] = -2*fx_mul(tp, r); v[9][3] = 2*fx_mul(r, u);
      v[9][4] = -4*tp; v[9][7] = -2*tp; v[9][8] = -2*r; v[9][9] = 2*(u - r);
      v[10][0] = 2*fx_mul(tp, fx_mul(r, s));
      v[10][1] = 2*fx_mul(tp, s); v[10][2] = 2*fx_mul(tp, r); v[10][3] = 2*fx_mul(r, s);
      v[10][7] = 2*tp; v[10][8] = 2*r; v[10][9] = 2*s;
      v[11][0] = 2*fx_mul(tp, fx_mul(s, u));
      v[11][1] = -2*fx_mul(tp, s); v[11][2] = 2*fx_mul(tp, u - s); v[11][3] = 2*fx_mul(s, u);
      v[11][5] = -4*tp; v[11][7] = -2*tp; v[11][8] = 2*(u - s); v[11][9] = -2*s;
      // vertical edge midpoints
      v[12][0] = fx_mul(q, u);
      v[12][1] = -q; v[12][2] = -q; v[12][3] = -2*fx_mul(t, u);
      v[12][6] = -2*u; v[12][8] = 2*t; v[12][9] = 2*t;
      v[13][0] = fx_mul(q, r);
      v[13][1] = q; v[13][3] = -2*fx_mul(r, t);
      v[13][6] = -2*r; v[13][9] = -2*t;
      v[14][0] = fx_mul(q, s);
      v[14][2] = q; v[14][3] = -2*fx_mul(s, t);
      v[14][6] = -2*s; v[14][8] = -2*t;
      for (int k = 0; k < w15sf_pkg::NODE_COUNT; k++) begin
         w.node = k[3:0];
         for (int j = 0; j < 10; j++) w.vals[j] = clamp_out(v[k][j]);
         w.last = (k == w15sf_pkg::NODE_COUNT - 1);
         pending_words.push_back(w);
      end
   endtask

   // send one point, with random sender gaps
   task automatic send_point(logic [w15sf_pkg::R_W-1:0] r, logic [w15sf_pkg::S_W-1:0] s,
                             logic signed [w15sf_pkg::T_W-1:0] t);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_coord_r <= r; req_coord_s <= s; req_coord_t <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_wedge_nodes(r, s, t);
   endtask

   // word checker
   always @(posedge clock) begin
      node_word_type w;
      longint got [10];
      bit bad;
      if (!reset && rsp_valid) begin
         got[0] = longint'(rsp_shape_value); got[1] = longint'(rsp_grad_r);
         got[2] = longint'(rsp_grad_s); got[3] = longint'(rsp_grad_t);
         got[4] = longint'(rsp_curv_rr); got[5] = longint'(rsp_curv_ss);
         got[6] = longint'(rsp_curv_tt); got[7] = longint'(rsp_curv_rs);
         got[8] = longint'(rsp_curv_st); got[9] = longint'(rsp_curv_rt);
         if (pending_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word node %0d", rsp_node_index);
         end else begin
            w = pending_words.pop_front();
            bad = (rsp_node_index !== w.node) || (rsp_last_node !== w.last);
            for (int j = 0; j < 10; j++) if (got[j] != w.vals[j]) bad = 1;
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch node exp %0d got %0d last exp %0b got %0b exp %p got %p",
                           w.node, rsp_node_index, w.last, rsp_last_node, w.vals, got);
            end
         end
      end
   end

   function automatic logic signed [w15sf_pkg::T_W-1:0] rand_t_in();
      return w15sf_pkg::T_W'($signed($urandom_range(131072)) - 65536);
   endfunction

   // corners, edges, extremes and all-ones bits
   task automatic test_directed();
      send_point(17'd0, 17'd0, 18'sd0);
      send_point(17'd0, 17'd0, -18'sd65536);
      send_point(17'd0, 17'd0, 18'sd65536);
      send_point(17'd65536, 17'd0, -18'sd65536);
      send_point(17'd0, 17'd65536, 18'sd65536);
      send_point(17'd32768, 17'd0, 18'sd0);
      send_point(17'd0, 17'd32768, 18'sd32768);
      send_point(17'd32768, 17'd32768, -18'sd32768);
      send_point(17'd21845, 17'd21845, 18'sd0);
      send_point(17'd65536, 17'd65536, 18'sd65536);
      // outside the element, saturating; then two points just inside it
      send_point(17'h1FFFF, 17'h1FFFF, 18'sh1FFFF);
      send_point(17'h1FFFF, 17'h1FFFF, 18'sh20000);
      send_point(17'h1FFFF, 17'd0, 18'sh20000);
      send_point(17'd0, 17'h1FFFF, 18'sh3FFFF);
      send_point(17'd1, 17'd1, 18'sd1);
      send_point(17'd65535, 17'd1, -18'sd1);
   endtask

   // random points, mostly inside the element
   task automatic test_random(int count);
      logic [w15sf_pkg::R_W-1:0] r;
      logic [w15sf_pkg::S_W-1:0] s;
      logic signed [w15sf_pkg::T_W-1:0] t;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 8) begin
            r = w15sf_pkg::R_W'($urandom_range(65536));
            s = w15sf_pkg::S_W'($urandom_range(65536 - int'(r)));
            t = rand_t_in();
         end else begin
            r = w15sf_pkg::R_W'($urandom);
            s = w15sf_pkg::S_W'($urandom);
            t = w15sf_pkg::T_W'($urandom);
         end
         send_point(r, s, t);
      end
   endtask

   task automatic drain_words();
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1; start = 1'b0;
      req_coord_r = '0; req_coord_s = '0; req_coord_t = '0;
      mismatch_count = 0; idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      idle_pct = 0;  test_random(100);
      idle_pct = 60; test_random(80);
      idle_pct = 0;  test_random(70);
      idle_pct = 17; test_random(70);
      drain_words();
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### wedge15_shape_function_eval.f
rtl/w15sf_pkg.sv
rtl/wedge15_shape_function_eval.sv
bench/wedge15_shape_function_eval_tb.sv
